// ===== design/rbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rbr_pkg
// Shared constants and types for the radiative boundary right-hand side.
// ----------------------------------------------------------------------------
package rbr_pkg;

    localparam int PAD_WIDTH = 3;
    localparam int MAX_EDGE  = 64;

    localparam int IDX_W  = 6;
    localparam int SIZE_W = 7;
    localparam int MASK_W = 6;
    localparam int Q_W    = 32;
    localparam int SP_W   = 31;
    localparam int CFG_W  = 3;

    // |sum of five Q32.32 products| < 2^65, floored by 2^16
    localparam int SUM_W  = 67;
    localparam int NUM_W  = SUM_W - 16;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [CFG_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_SPACING_X  = 3'd3,
        CFG_SPACING_Y  = 3'd4,
        CFG_SPACING_Z  = 3'd5,
        CFG_FALLOFF    = 3'd6,
        CFG_ASYMPTOTIC = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                  ov;
        logic signed [Q_W-1:0] val;
    } coord_t;

    // sideband that rides alongside the square root
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             ov;
        logic             num_pos;
        logic             num_zero;
        logic [NUM_W-1:0] mag;
    } sq_side_t;

    // sideband that rides alongside the divider
    typedef struct packed {
        logic valid;
        logic hit;
        logic ov;
        logic num_pos;
        logic num_zero;
        logic r_zero;
        logic big;
    } dv_side_t;

endpackage

// ===== design/radiative_boundary_rhs.sv =====
// ----------------------------------------------------------------------------
// radiative_boundary_rhs
// Sommerfeld radiative boundary term for one grid point, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  -------   -----------------------   ----------------------------------------
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//  point     point_valid / point_stall index_i..k, field_value, deriv_x..z,
//                                      face_mask, size_x..z
//  rhs       rhs_valid / rhs_stall     rhs_value, write_enable, overflow
//
//  One point per cycle, save that the whole pipeline advances together and
//  holds while a result sits unaccepted under rhs_stall. It has three
//  arithmetic stages, the 32-stage square root, divider set-up, the 32-stage
//  divider and the output register. Reset clears the valid bits and loads
//  the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module radiative_boundary_rhs (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbr_pkg::CFG_W-1:0]         cfg_index,
    input  logic [rbr_pkg::Q_W-1:0]           cfg_data,

    input  logic                              point_valid,
    output logic                              point_stall,
    input  logic [rbr_pkg::IDX_W-1:0]         index_i,
    input  logic [rbr_pkg::IDX_W-1:0]         index_j,
    input  logic [rbr_pkg::IDX_W-1:0]         index_k,
    input  logic signed [rbr_pkg::Q_W-1:0]    field_value,
    input  logic signed [rbr_pkg::Q_W-1:0]    deriv_x,
    input  logic signed [rbr_pkg::Q_W-1:0]    deriv_y,
    input  logic signed [rbr_pkg::Q_W-1:0]    deriv_z,
    input  logic [rbr_pkg::MASK_W-1:0]        face_mask,
    input  logic [rbr_pkg::SIZE_W-1:0]        size_x,
    input  logic [rbr_pkg::SIZE_W-1:0]        size_y,
    input  logic [rbr_pkg::SIZE_W-1:0]        size_z,

    output logic                              rhs_valid,
    input  logic                              rhs_stall,
    output logic signed [rbr_pkg::Q_W-1:0]    rhs_value,
    output logic                              write_enable,
    output logic                              overflow
);
    import rbr_pkg::*;

    localparam int NS    = ROOT_W;
    localparam int EXT_W = SIZE_W + 2;
    localparam int PRD_W = IDX_W + SP_W;
    localparam int CRD_W = PRD_W + 2;
    localparam int PRQ_W = 2 * Q_W;

    localparam logic signed [EXT_W-1:0] PAD_S  = EXT_W'(PAD_WIDTH);
    localparam logic signed [EXT_W-1:0] FAR_OF = EXT_W'(PAD_WIDTH + 1);
    localparam logic [SIZE_W-1:0]       EDGE_C = SIZE_W'(MAX_EDGE);

    function automatic coord_t sat_coord(input logic signed [CRD_W-1:0] v);
        coord_t c;
        if (v > CRD_W'(Q_MAX))
        begin
            c.ov  = 1'b1;
            c.val = Q_MAX;
        end
        else if (v < CRD_W'(Q_MIN))
        begin
            c.ov  = 1'b1;
            c.val = Q_MIN;
        end
        else
        begin
            c.ov  = 1'b0;
            c.val = v[Q_W-1:0];
        end
        return c;
    endfunction

    // ---------------- configuration ----------------
    logic signed [Q_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [SP_W-1:0]       spacing_x_reg, spacing_y_reg, spacing_z_reg;
    logic signed [Q_W-1:0] falloff_reg, asym_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            spacing_x_reg <= SP_W'(65536);
            spacing_y_reg <= SP_W'(65536);
            spacing_z_reg <= SP_W'(65536);
            falloff_reg   <= Q_W'(65536);
            asym_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ORIGIN_X:   origin_x_reg  <= cfg_data;
                CFG_ORIGIN_Y:   origin_y_reg  <= cfg_data;
                CFG_ORIGIN_Z:   origin_z_reg  <= cfg_data;
                CFG_SPACING_X:  spacing_x_reg <= cfg_data[SP_W-1:0];
                CFG_SPACING_Y:  spacing_y_reg <= cfg_data[SP_W-1:0];
                CFG_SPACING_Z:  spacing_z_reg <= cfg_data[SP_W-1:0];
                CFG_FALLOFF:    falloff_reg   <= cfg_data;
                CFG_ASYMPTOTIC: asym_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic adv;

    assign adv         = !(rhs_valid && rhs_stall);
    assign point_stall = !adv;

    // ---------------- stage 1: face test and coordinates ----------------
    logic [SIZE_W-1:0]       sx_c, sy_c, sz_c;
    logic signed [EXT_W-1:0] far_x, far_y, far_z;
    logic signed [EXT_W-1:0] ii, jj, kk;
    logic                    in_i, in_j, in_k;
    logic                    hit_c;
    logic [PRD_W-1:0]        ix_c, jy_c, kz_c;
    coord_t                  cx_c, cy_c, cz_c;

    always_comb
    begin
        sx_c  = (size_x > EDGE_C) ? EDGE_C : size_x;
        sy_c  = (size_y > EDGE_C) ? EDGE_C : size_y;
        sz_c  = (size_z > EDGE_C) ? EDGE_C : size_z;
        far_x = signed'({2'b00, sx_c}) - FAR_OF;
        far_y = signed'({2'b00, sy_c}) - FAR_OF;
        far_z = signed'({2'b00, sz_c}) - FAR_OF;
        ii    = signed'(EXT_W'(index_i));
        jj    = signed'(EXT_W'(index_j));
        kk    = signed'(EXT_W'(index_k));
        in_i  = (ii >= PAD_S) && (ii <= far_x);
        in_j  = (jj >= PAD_S) && (jj <= far_y);
        in_k  = (kk >= PAD_S) && (kk <= far_z);
        hit_c = (face_mask[0] && ii == PAD_S && in_j && in_k)
             || (face_mask[1] && ii == far_x && in_j && in_k)
             || (face_mask[2] && jj == PAD_S && in_i && in_k)
             || (face_mask[3] && jj == far_y && in_i && in_k)
             || (face_mask[4] && kk == PAD_S && in_i && in_j)
             || (face_mask[5] && kk == far_z && in_i && in_j);

        ix_c = PRD_W'(index_i) * PRD_W'(spacing_x_reg);
        jy_c = PRD_W'(index_j) * PRD_W'(spacing_y_reg);
        kz_c = PRD_W'(index_k) * PRD_W'(spacing_z_reg);
        cx_c = sat_coord(CRD_W'(origin_x_reg) + signed'({2'b00, ix_c}));
        cy_c = sat_coord(CRD_W'(origin_y_reg) + signed'({2'b00, jy_c}));
        cz_c = sat_coord(CRD_W'(origin_z_reg) + signed'({2'b00, kz_c}));
    end

    logic                  s1_valid_reg, s1_hit_reg, s1_ov_reg;
    logic signed [Q_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic signed [Q_W-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg, s1_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hit_reg <= hit_c;
            s1_ov_reg  <= cx_c.ov | cy_c.ov | cz_c.ov;
            s1_x_reg   <= cx_c.val;
            s1_y_reg   <= cy_c.val;
            s1_z_reg   <= cz_c.val;
            s1_dx_reg  <= deriv_x;
            s1_dy_reg  <= deriv_y;
            s1_dz_reg  <= deriv_z;
            s1_f_reg   <= field_value;
        end
    end

    // ---------------- stage 2: products ----------------
    logic                    s2_valid_reg, s2_hit_reg, s2_ov_reg;
    logic signed [PRQ_W-1:0] s2_pxd_reg, s2_pyd_reg, s2_pzd_reg, s2_pff_reg, s2_pfa_reg;
    logic signed [PRQ_W-1:0] s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_hit_reg <= s1_hit_reg;
            s2_ov_reg  <= s1_ov_reg;
            s2_pxd_reg <= s1_x_reg * s1_dx_reg;
            s2_pyd_reg <= s1_y_reg * s1_dy_reg;
            s2_pzd_reg <= s1_z_reg * s1_dz_reg;
            s2_pff_reg <= falloff_reg * s1_f_reg;
            s2_pfa_reg <= falloff_reg * asym_reg;
            s2_sqx_reg <= s1_x_reg * s1_x_reg;
            s2_sqy_reg <= s1_y_reg * s1_y_reg;
            s2_sqz_reg <= s1_z_reg * s1_z_reg;
        end
    end

    // ---------------- stage 3: numerator and radius squared ----------------
    logic signed [SUM_W-1:0] sum_c;
    logic [RAD_W-1:0]        r2_c;

    always_comb
    begin
        sum_c = SUM_W'(s2_pxd_reg) + SUM_W'(s2_pyd_reg) + SUM_W'(s2_pzd_reg)
              + SUM_W'(s2_pff_reg) - SUM_W'(s2_pfa_reg);
        // squares are non-negative, their sum stays below 2^64
        r2_c  = RAD_W'(s2_sqx_reg) + RAD_W'(s2_sqy_reg) + RAD_W'(s2_sqz_reg);
    end

    logic                    s3_valid_reg, s3_hit_reg, s3_ov_reg;
    logic signed [NUM_W-1:0] s3_num_reg;
    logic [RAD_W-1:0]        s3_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_hit_reg <= s2_hit_reg;
            s3_ov_reg  <= s2_ov_reg;
            s3_num_reg <= sum_c[SUM_W-1:16];   // arithmetic floor by 2^16
            s3_r2_reg  <= r2_c;
        end
    end

    // ---------------- square root ----------------
    logic [ROOT_W-1:0] root_w;
    sq_side_t          sq_side_next;
    sq_side_t          sq_side_reg[NS];

    rbr_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (s3_r2_reg),
        .root (root_w)
    );

    always_comb
    begin
        sq_side_next.valid    = s3_valid_reg;
        sq_side_next.hit      = s3_hit_reg;
        sq_side_next.ov       = s3_ov_reg;
        sq_side_next.num_pos  = !s3_num_reg[NUM_W-1] && (s3_num_reg != '0);
        sq_side_next.num_zero = (s3_num_reg == '0);
        sq_side_next.mag      = s3_num_reg[NUM_W-1] ? NUM_W'(-s3_num_reg)
                                                     : NUM_W'(s3_num_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                sq_side_reg[s] <= '0;
        end
        else if (adv)
        begin
            sq_side_reg[0] <= sq_side_next;
            for (int s = 1; s < NS; s++)
                sq_side_reg[s] <= sq_side_reg[s-1];
        end
    end

    // ---------------- divider set-up ----------------
    // quotient is mag * 2^16 / r; it needs more than 32 bits when mag / 2^16 >= r
    sq_side_t          sq_last;
    dv_side_t          di_side_next;
    dv_side_t          di_side_reg;
    logic [ROOT_W-1:0] di_rem_reg, di_low_reg, di_div_reg;

    assign sq_last = sq_side_reg[NS-1];

    always_comb
    begin
        di_side_next.valid    = sq_last.valid;
        di_side_next.hit      = sq_last.hit;
        di_side_next.ov       = sq_last.ov;
        di_side_next.num_pos  = sq_last.num_pos;
        di_side_next.num_zero = sq_last.num_zero;
        di_side_next.r_zero   = (root_w == '0);
        di_side_next.big      = sq_last.mag[NUM_W-1:16] >= (NUM_W-16)'(root_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            di_side_reg <= '0;
        else if (adv)
            di_side_reg <= di_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            di_rem_reg <= sq_last.mag[ROOT_W+15:16];
            di_low_reg <= {sq_last.mag[15:0], 16'h0000};
            di_div_reg <= root_w;
        end
    end

    // ---------------- divider ----------------
    logic [ROOT_W-1:0] quot_w;
    dv_side_t          dv_side_reg[NS];

    rbr_divq u_divq (
        .clk     (clk),
        .en      (adv),
        .rem0    (di_rem_reg),
        .low     (di_low_reg),
        .divisor (di_div_reg),
        .quot    (quot_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                dv_side_reg[s] <= '0;
        end
        else if (adv)
        begin
            dv_side_reg[0] <= di_side_reg;
            for (int s = 1; s < NS; s++)
                dv_side_reg[s] <= dv_side_reg[s-1];
        end
    end

    // ---------------- result ----------------
    dv_side_t              dv_last;
    logic signed [Q_W-1:0] res_c;
    logic                  ov_c;
    logic                  we_c;

    assign dv_last = dv_side_reg[NS-1];

    always_comb
    begin
        res_c = '0;
        ov_c  = 1'b0;
        we_c  = dv_last.hit;
        if (dv_last.hit)
        begin
            ov_c = dv_last.ov;
            if (dv_last.r_zero)
            begin
                ov_c = 1'b1;
                if (!dv_last.num_zero)
                    res_c = dv_last.num_pos ? Q_MIN : Q_MAX;
            end
            else if (dv_last.big)
            begin
                ov_c  = 1'b1;
                res_c = dv_last.num_pos ? Q_MIN : Q_MAX;
            end
            else if (dv_last.num_pos)
            begin
                if (quot_w > ROOT_W'(Q_MIN))
                begin
                    ov_c  = 1'b1;
                    res_c = Q_MIN;
                end
                else
                    res_c = Q_W'(-quot_w);
            end
            else
            begin
                if (quot_w > ROOT_W'(Q_MAX))
                begin
                    ov_c  = 1'b1;
                    res_c = Q_MAX;
                end
                else
                    res_c = Q_W'(quot_w);
            end
        end
    end

    logic                  out_valid_reg;
    logic signed [Q_W-1:0] out_value_reg;
    logic                  out_we_reg, out_ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_value_reg <= res_c;
            out_we_reg    <= we_c;
            out_ov_reg    <= ov_c;
        end
    end

    assign rhs_valid    = out_valid_reg;
    assign rhs_value    = out_value_reg;
    assign write_enable = out_we_reg;
    assign overflow     = out_ov_reg;

endmodule

// ===== design/rbr_isqrt.sv =====
// ----------------------------------------------------------------------------
// rbr_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rbr_isqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rbr_pkg::RAD_W-1:0]   rad,
    output logic [rbr_pkg::ROOT_W-1:0]  root
);
    import rbr_pkg::*;

    localparam int NS    = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [NS];
    logic [REM_W-1:0]  rem_next [NS];
    logic [ROOT_W-1:0] root_reg [NS];
    logic [ROOT_W-1:0] root_next[NS];
    logic [RAD_W-1:0]  rad_reg  [NS];
    logic [RAD_W-1:0]  rad_next [NS];

    logic [REM_W-1:0]  rem_src  [NS];
    logic [ROOT_W-1:0] root_src [NS];
    logic [RAD_W-1:0]  rad_src  [NS];

    always_comb
    begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = rad;
        for (int s = 1; s < NS; s++)
        begin
            rem_src[s]  = rem_reg[s-1];
            root_src[s] = root_reg[s-1];
            rad_src[s]  = rad_reg[s-1];
        end
    end

    always_comb
    begin
        logic [REM_W-1:0] rr;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < NS; s++)
        begin
            // remainder stays below 2^32 ahead of each shift
            rr    = {rem_src[s][REM_W-3:0], rad_src[s][RAD_W-1 -: 2]};
            trial = {root_src[s], 2'b01};
            if (rr >= trial)
            begin
                rem_next[s]  = rr - trial;
                root_next[s] = {root_src[s][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rr;
                root_next[s] = {root_src[s][ROOT_W-2:0], 1'b0};
            end
            rad_next[s] = {rad_src[s][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
            end
        end
    end

    assign root = root_reg[NS-1];

endmodule

// ===== design/rbr_divq.sv =====
// ----------------------------------------------------------------------------
// rbr_divq
// Pipelined restoring divider, one quotient bit per stage. The initial
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module rbr_divq (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rbr_pkg::ROOT_W-1:0]  rem0,
    input  logic [rbr_pkg::ROOT_W-1:0]  low,
    input  logic [rbr_pkg::ROOT_W-1:0]  divisor,
    output logic [rbr_pkg::ROOT_W-1:0]  quot
);
    import rbr_pkg::*;

    localparam int NS = ROOT_W;

    logic [ROOT_W-1:0] rem_reg  [NS];
    logic [ROOT_W-1:0] rem_next [NS];
    logic [ROOT_W-1:0] low_reg  [NS];
    logic [ROOT_W-1:0] low_next [NS];
    logic [ROOT_W-1:0] quo_reg  [NS];
    logic [ROOT_W-1:0] quo_next [NS];
    logic [ROOT_W-1:0] dvs_reg  [NS];

    logic [ROOT_W-1:0] rem_src  [NS];
    logic [ROOT_W-1:0] low_src  [NS];
    logic [ROOT_W-1:0] quo_src  [NS];
    logic [ROOT_W-1:0] dvs_src  [NS];

    always_comb
    begin
        rem_src[0] = rem0;
        low_src[0] = low;
        quo_src[0] = '0;
        dvs_src[0] = divisor;
        for (int s = 1; s < NS; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            low_src[s] = low_reg[s-1];
            quo_src[s] = quo_reg[s-1];
            dvs_src[s] = dvs_reg[s-1];
        end
    end

    always_comb
    begin
        logic [ROOT_W:0] t;
        logic            ge;
        for (int s = 0; s < NS; s++)
        begin
            t  = {rem_src[s], low_src[s][ROOT_W-1]};
            ge = (t >= {1'b0, dvs_src[s]});
            if (ge)
                rem_next[s] = ROOT_W'(t - {1'b0, dvs_src[s]});
            else
                rem_next[s] = t[ROOT_W-1:0];
            low_next[s] = {low_src[s][ROOT_W-2:0], 1'b0};
            quo_next[s] = {quo_src[s][ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
                dvs_reg[s] <= dvs_src[s];
            end
        end
    end

    assign quot = quo_reg[NS-1];

endmodule

// ===== design/rbr_checker.sv =====
// ----------------------------------------------------------------------------
// rbr_checker
// Port-level checks for the radiative boundary right-hand side.
// ----------------------------------------------------------------------------
module rbr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_ready,
    input logic                            point_stall,
    input logic                            rhs_valid,
    input logic                            rhs_stall,
    input logic signed [rbr_pkg::Q_W-1:0]  rhs_value,
    input logic                            write_enable,
    input logic                            overflow
);
    import rbr_pkg::*;

    // points off the boundary carry a clean zero result
    a_off_face_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rhs_valid && !write_enable |-> rhs_value == '0 && !overflow)
        else $error("off-face result not zero");

    a_ov_needs_we: assert property (@(posedge clk) disable iff (!rst_n)
        rhs_valid && overflow |-> write_enable)
        else $error("overflow flagged without write");

    // input only held back by a blocked result transfer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> rhs_valid && rhs_stall)
        else $error("input stalled without output back-pressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rhs_valid && rhs_stall |=> rhs_valid && $stable(rhs_value))
        else $error("stalled result changed");

endmodule

bind radiative_boundary_rhs rbr_checker u_rbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .point_stall  (point_stall),
    .rhs_valid    (rhs_valid),
    .rhs_stall    (rhs_stall),
    .rhs_value    (rhs_value),
    .write_enable (write_enable),
    .overflow     (overflow)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radiative_boundary_rhs: a directed table of grid
// points, then constrained-by-hand random points, across several register
// settings; results are checked against table values or a local predictor.
// ----------------------------------------------------------------------------
module tb;
    import rbr_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]      i, j, k;
        logic signed [Q_W-1:0] f, dx, dy, dz;
        logic [MASK_W-1:0]     mask;
        logic [SIZE_W-1:0]     sx, sy, sz;
    } grid_point_t;

    typedef struct {
        logic signed [Q_W-1:0] val;
        logic                  we;
        logic                  ov;
    } rhs_t;

    typedef struct {
        grid_point_t pt;
        bit          typed;
        rhs_t        res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_index = '0;
    logic [Q_W-1:0] cfg_data = '0;
    logic point_valid = 1'b0;
    logic point_stall;
    logic [IDX_W-1:0] index_i = '0, index_j = '0, index_k = '0;
    logic signed [Q_W-1:0] field_value = '0, deriv_x = '0, deriv_y = '0, deriv_z = '0;
    logic [MASK_W-1:0] face_mask = '0;
    logic [SIZE_W-1:0] size_x = '0, size_y = '0, size_z = '0;
    logic rhs_valid;
    logic rhs_stall = 1'b0;
    logic signed [Q_W-1:0] rhs_value;
    logic write_enable;
    logic overflow;

    // local copy of the register file
    logic signed [Q_W-1:0] org_c[3];
    logic [SP_W-1:0]       step_c[3];
    logic signed [Q_W-1:0] falloff_c, asym_c;

    rhs_t pending_rhs[$];
    int   errors = 0;
    int   n_points = 0, n_results = 0, n_hits = 0, n_sat = 0;
    int   quiet = 0;
    bit   calm = 1'b0;
    table_row_t rows[$];

    always #4 clk = ~clk;

    radiative_boundary_rhs dut (.*);

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic rhs_t boundary_rhs(grid_point_t p);
        int sz[3], id[3], b, c, a;
        bit hit, ov;
        bit inb, inc;
        longint crd[3], t;
        logic signed [79:0] acc;
        longint num;
        logic [63:0] r2, r, mag, q1, q;
        longint res;
        rhs_t o;
        id[0] = p.i; id[1] = p.j; id[2] = p.k;
        sz[0] = p.sx; sz[1] = p.sy; sz[2] = p.sz;
        hit = 0;
        ov = 0;
        for (a = 0; a < 3; a++)
            if (sz[a] > MAX_EDGE) sz[a] = MAX_EDGE;
        for (a = 0; a < 3; a++)
        begin
            b = (a + 1) % 3;
            c = (a + 2) % 3;
            inb = id[b] >= PAD_WIDTH && id[b] <= sz[b] - PAD_WIDTH - 1;
            inc = id[c] >= PAD_WIDTH && id[c] <= sz[c] - PAD_WIDTH - 1;
            if (p.mask[2*a] && id[a] == PAD_WIDTH && inb && inc) hit = 1;
            if (p.mask[2*a+1] && id[a] == sz[a] - PAD_WIDTH - 1 && inb && inc) hit = 1;
        end
        o.val = '0; o.we = 0; o.ov = 0;
        if (!hit) return o;
        for (a = 0; a < 3; a++)
        begin
            t = longint'(org_c[a]) + longint'(id[a]) * longint'({1'b0, step_c[a]});
            if (t > longint'(Q_MAX)) begin t = Q_MAX; ov = 1; end
            if (t < longint'(Q_MIN)) begin t = Q_MIN; ov = 1; end
            crd[a] = t;
        end
        acc = 0;
        acc = acc + crd[0] * p.dx + crd[1] * p.dy + crd[2] * p.dz;
        acc = acc + falloff_c * p.f - falloff_c * asym_c;
        num = longint'(acc >>> 16);
        r2 = crd[0] * crd[0] + crd[1] * crd[1] + crd[2] * crd[2];
        r = root64(r2);
        if (r == 0)
        begin
            ov = 1;
            res = num == 0 ? 0 : (num > 0 ? longint'(Q_MIN) : longint'(Q_MAX));
        end
        else
        begin
            mag = num < 0 ? -num : num;
            q1 = mag / r;
            if (q1 > 32768)
            begin
                res = num > 0 ? longint'(Q_MIN) : longint'(Q_MAX);
                ov = 1;
            end
            else
            begin
                q = (q1 << 16) + (((mag % r) << 16) / r);
                res = num > 0 ? -longint'(q) : longint'(q);
                if (res > longint'(Q_MAX)) begin res = Q_MAX; ov = 1; end
                if (res < longint'(Q_MIN)) begin res = Q_MIN; ov = 1; end
            end
        end
        o.val = res[31:0];
        o.we = 1;
        o.ov = ov;
        return o;
    endfunction

    function automatic grid_point_t mk_point(int i, int j, int k, int m, int sx, int sy,
                                            int sz, logic [31:0] f, logic [31:0] dx,
                                            logic [31:0] dy, logic [31:0] dz);
        grid_point_t p;
        p.i = i; p.j = j; p.k = k; p.mask = m;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.f = f; p.dx = dx; p.dy = dy; p.dz = dz;
        return p;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return {1'b0, {31{1'b1}}};
            1: return {1'b1, {31{1'b0}}};
            2: return $urandom_range(0, 32'h3ffff);
            3: return -$urandom_range(0, 32'h3ffff);
            default: return $urandom;
        endcase
    endfunction

    // mostly points on a face of a sensible block, the rest anything at all
    function automatic grid_point_t rand_point();
        grid_point_t p;
        int s[3], id[3], a, lim;
        p = mk_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, rand_q(), rand_q(), rand_q(), rand_q());
        if ($urandom_range(0, 99) < 70)
        begin
            for (a = 0; a < 3; a++)
            begin
                s[a] = $urandom_range(0, 9) == 0 ? $urandom_range(65, 127)
                                                 : $urandom_range(8, 64);
                lim = s[a] > MAX_EDGE ? MAX_EDGE : s[a];
                id[a] = $urandom_range(PAD_WIDTH, lim - PAD_WIDTH - 1);
            end
            a = $urandom_range(0, 2);
            lim = s[a] > MAX_EDGE ? MAX_EDGE : s[a];
            id[a] = $urandom_range(0, 1) ? PAD_WIDTH : lim - PAD_WIDTH - 1;
            p.i = id[0]; p.j = id[1]; p.k = id[2];
            p.sx = s[0]; p.sy = s[1]; p.sz = s[2];
            if ($urandom_range(0, 3) != 0) p.mask = p.mask | (6'd3 << (2*a));
        end
        return p;
    endfunction

    task automatic send_point(grid_point_t p, bit typed, rhs_t res);
        // one idle decision per cycle keeps the idle share near a quarter
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        index_i <= p.i; index_j <= p.j; index_k <= p.k;
        field_value <= p.f; deriv_x <= p.dx; deriv_y <= p.dy; deriv_z <= p.dz;
        face_mask <= p.mask; size_x <= p.sx; size_y <= p.sy; size_z <= p.sz;
        @(posedge clk);
        while (point_stall) @(posedge clk);
        pending_rhs.push_back(typed ? res : boundary_rhs(p));
        n_points++;
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        while (pending_rhs.size() != 0) @(posedge clk);
        // every point, on a face or not, queued a result; idle on past the last one
        repeat (75) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_ORIGIN_X:  org_c[0] = d;
            CFG_ORIGIN_Y:  org_c[1] = d;
            CFG_ORIGIN_Z:  org_c[2] = d;
            CFG_SPACING_X: step_c[0] = d[SP_W-1:0];
            CFG_SPACING_Y: step_c[1] = d[SP_W-1:0];
            CFG_SPACING_Z: step_c[2] = d[SP_W-1:0];
            CFG_FALLOFF:   falloff_c = d;
            default:       asym_c = d;
        endcase
    endtask

    task automatic load_regs(logic [31:0] o, logic [31:0] sp, logic [31:0] fr,
                             logic [31:0] av);
        drain();
        cfg_write(CFG_ORIGIN_X, o);
        cfg_write(CFG_ORIGIN_Y, $urandom_range(0, 1) ? o : rand_q());
        cfg_write(CFG_ORIGIN_Z, o);
        cfg_write(CFG_SPACING_X, sp);
        cfg_write(CFG_SPACING_Y, sp);
        cfg_write(CFG_SPACING_Z, sp);
        cfg_write(CFG_FALLOFF, fr);
        cfg_write(CFG_ASYMPTOTIC, av);
        cfg_valid <= 1'b0;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        rhs_t e;
        if (rhs_valid && !rhs_stall && rst_n)
        begin
            n_results++;
            if (pending_rhs.size() == 0)
            begin
                $display("%0t: unexpected result val=%h we=%b ov=%b", $time,
                         rhs_value, write_enable, overflow);
                errors++;
            end
            else
            begin
                e = pending_rhs.pop_front();
                if (e.we) n_hits++;
                if (e.ov) n_sat++;
                if (rhs_value !== e.val)
                begin
                    $display("%0t: rhs_value exp %h got %h", $time, e.val, rhs_value);
                    errors++;
                end
                if (write_enable !== e.we)
                begin
                    $display("%0t: write_enable exp %b got %b", $time, e.we, write_enable);
                    errors++;
                end
                if (overflow !== e.ov)
                begin
                    $display("%0t: overflow exp %b got %b", $time, e.ov, overflow);
                    errors++;
                end
            end
        end
        if (rst_n)
            rhs_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (rhs_valid && !rhs_stall)
            || (cfg_valid && cfg_ready) || !rst_n)
            quiet <= 0;
        else if (quiet >= 3000)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        rhs_t none, on_zero;
        int ph, n;
        logic [31:0] sp;
        none.val = '0; none.we = 0; none.ov = 0;
        on_zero.val = '0; on_zero.we = 1; on_zero.ov = 0;
        for (n = 0; n < 3; n++)
        begin
            org_c[n] = 0;
            step_c[n] = 65536;
        end
        falloff_c = 65536;
        asym_c = 0;

        // directed table, run under the reset register values
        rows.push_back('{mk_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk_point(3, 3, 3, 1, 64, 64, 64, 0, 0, 0, 0), 1, on_zero});
        rows.push_back('{mk_point(3, 3, 3, 2, 64, 64, 64, 5, 5, 5, 5), 1, none});
        rows.push_back('{mk_point(63, 63, 63, 63, 64, 64, 64, 1, 1, 1, 1), 1, none});
        rows.push_back('{mk_point(60, 3, 3, 63, 3, 3, 3, 1, 1, 1, 1), 1, none});
        rows.push_back('{mk_point(3, 3, 3, 63, 64, 64, 64, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff), 0, none});
        rows.push_back('{mk_point(60, 10, 20, 2, 64, 64, 64, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000), 0, none});
        rows.push_back('{mk_point(10, 3, 20, 4, 64, 64, 64, 32'h10000, 32'hffff0000,
                                  32'h20000, 0), 0, none});
        rows.push_back('{mk_point(10, 60, 20, 8, 64, 64, 64, 32'h7fffffff, 0, 32'h80000000,
                                  32'h7fffffff), 0, none});
        rows.push_back('{mk_point(30, 40, 3, 16, 64, 64, 64, 32'h12345678, 1, 1, 1), 0, none});
        rows.push_back('{mk_point(30, 40, 60, 32, 64, 64, 64, 32'hdeadbeef, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff), 0, none});
        // oversized sizes clamp to the largest edge
        rows.push_back('{mk_point(60, 20, 20, 2, 127, 127, 127, 32'h8000, 32'h18000,
                                  32'hfffe0000, 32'h4000), 0, none});
        rows.push_back('{mk_point(3, 60, 60, 1, 127, 65, 100, 32'h7fffffff, 32'h80000000,
                                  32'h80000000, 32'h80000000), 0, none});
        // small blocks: far face next to, on, or below the near face
        rows.push_back('{mk_point(3, 3, 3, 63, 7, 7, 7, 1, 1, 1, 1), 0, none});
        rows.push_back('{mk_point(4, 4, 4, 63, 8, 8, 8, 32'hffffffff, 32'hffffffff,
                                  32'hffffffff, 32'hffffffff), 0, none});
        rows.push_back('{mk_point(2, 5, 5, 3, 6, 64, 64, 1, 1, 1, 1), 0, none});
        rows.push_back('{mk_point(3, 2, 5, 63, 64, 64, 64, 1, 1, 1, 1), 1, none});
        rows.push_back('{mk_point(21, 42, 63, 63, 64, 64, 64, 32'h55555555, 32'haaaaaaaa,
                                  32'h55555555, 32'haaaaaaaa), 1, none});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[n]) send_point(rows[n].pt, rows[n].typed, rows[n].res);

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: ;
                1: load_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                2: load_regs(32'h80000000, 32'd1, 32'h80000000, 32'h80000000);
                // near-corner x and z land on zero; the radius is zero when y does too
                3: load_regs(32'hfffd0000, 32'h10000, 32'h10000, 32'h8000);
                default:
                begin
                    sp = $urandom_range(1, 32'h40000);
                    load_regs(-$urandom_range(0, 32'h400000), sp, rand_q(), rand_q());
                end
            endcase
            calm = (ph == 5);
            for (n = 0; n < 235; n++)
            begin
                if (ph == 4 && n == 100) drain();
                send_point(rand_point(), 0, none);
            end
        end
        calm = 1'b0;
        point_valid <= 1'b0;
        while (pending_rhs.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("points sent %0d, results checked %0d, on a face %0d, saturated %0d",
                 n_points, n_results, n_hits, n_sat);
        $display("register settings covered: reset, both extremes, zero radius, random");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== radiative_boundary_rhs.f =====
design/rbr_pkg.sv
design/rbr_isqrt.sv
design/rbr_divq.sv
design/radiative_boundary_rhs.sv
design/rbr_checker.sv
tb/tb.sv
